// ===== rtl/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types, constants and helpers for the sorted priority queue: queue
// sizing, command and status codes, transaction structs and value conversion.
// ----------------------------------------------------------------------------
package spq_pkg;

    // queue sizing
    localparam int CAPACITY    = 16;
    localparam int VALUE_WIDTH = 32;
    localparam int DATA_W      = 32;
    localparam int CMD_W       = 3;
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int IDX_W       = $clog2(CAPACITY);

    typedef logic signed [VALUE_WIDTH-1:0] t_value;

    // command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT    = 3'd0,
        CMD_REMOVE    = 3'd1,
        CMD_PEEK_HEAD = 3'd2,
        CMD_PEEK_TAIL = 3'd3,
        CMD_CLEAR     = 3'd4
    } t_cmd_code;

    // status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // input transaction
    typedef struct packed {
        logic [CMD_W-1:0]         cmd;
        logic signed [DATA_W-1:0] value;
    } t_cmd_in;

    // result transaction
    typedef struct packed {
        logic signed [DATA_W-1:0] data;
        logic                     data_valid;
        logic [1:0]               status;
        logic [CNT_W-1:0]         occupancy;
    } t_result;

    // broadcast control to every cell of the chain
    typedef struct packed {
        logic   insert;
        logic   remove;
        t_value value;
    } t_cell_ctrl;

    // input word to stored width (sign-extend or truncate)
    function automatic t_value to_value(logic signed [DATA_W-1:0] x);
        return VALUE_WIDTH'(x);
    endfunction

    // stored value to output word (sign-extend or truncate)
    function automatic logic signed [DATA_W-1:0] to_data(t_value v);
        return DATA_W'(v);
    endfunction

endpackage

// ===== rtl/sorted_priority_queue_core.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_queue_core
// Bounded priority queue of signed values held in descending order in a
// chain of compare-and-shift cells.
// ----------------------------------------------------------------------------
// One command is taken every clock cycle (busy never rises) and its result
// appears on o_result, flagged by o_strobe, for the single cycle right after
// the command was taken. The rate is set by the cell chain: every cell
// compares its entry with the incoming value at once and shifts in one step,
// so an insert or remove is done before the next command. The receiver cannot
// stall the block; results must be captured in the cycle they are strobed.
// ----------------------------------------------------------------------------
module sorted_priority_queue_core
    import spq_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  t_cmd_in i_command,
    output logic    busy,
    output logic    o_strobe,
    output t_result o_result
);

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_strobe;
    t_result          r_result;
    t_result          n_result;

    logic             w_accept;
    logic             w_empty;
    logic             w_full;
    logic [IDX_W-1:0] w_tail_idx;
    t_value           w_in_value;
    t_cell_ctrl       w_ctrl;

    t_value           w_val [CAPACITY];
    logic             w_ge  [CAPACITY];

    assign busy       = 1'b0;
    assign w_accept   = start && !busy;
    assign w_empty    = (r_count == '0);
    assign w_full     = (r_count == CNT_W'(CAPACITY));
    assign w_in_value = to_value(i_command.value);
    assign w_tail_idx = IDX_W'(r_count - CNT_W'(1));

    // command decode and result
    always_comb begin
        n_count             = r_count;
        w_ctrl.insert       = 1'b0;
        w_ctrl.remove       = 1'b0;
        w_ctrl.value        = w_in_value;
        n_result.data       = '0;
        n_result.data_valid = 1'b0;
        n_result.status     = ST_OK;
        unique case (i_command.cmd)
            CMD_INSERT: begin
                if (w_full) begin
                    n_result.status = ST_FULL;
                end else begin
                    w_ctrl.insert = w_accept;
                    n_count       = r_count + CNT_W'(1);
                end
            end
            CMD_REMOVE: begin
                if (w_empty) begin
                    n_result.status = ST_EMPTY;
                end else begin
                    w_ctrl.remove       = w_accept;
                    n_count             = r_count - CNT_W'(1);
                    n_result.data       = to_data(w_val[0]);
                    n_result.data_valid = 1'b1;
                end
            end
            CMD_PEEK_HEAD: begin
                if (w_empty) begin
                    n_result.status = ST_EMPTY;
                end else begin
                    n_result.data       = to_data(w_val[0]);
                    n_result.data_valid = 1'b1;
                end
            end
            CMD_PEEK_TAIL: begin
                if (w_empty) begin
                    n_result.status = ST_EMPTY;
                end else begin
                    n_result.data       = to_data(w_val[w_tail_idx]);
                    n_result.data_valid = 1'b1;
                end
            end
            CMD_CLEAR: begin
                n_count = '0;
            end
            default: begin
            end
        endcase
        n_result.occupancy = n_count;
    end

    // chain of cells, head at index 0
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic   w_occ;
        logic   w_prev_ge;
        t_value w_prev_val;
        t_value w_next_val;

        assign w_occ = (r_count > CNT_W'(i));

        if (i == 0) begin : g_head
            assign w_prev_ge  = 1'b1;
            assign w_prev_val = w_in_value;
        end else begin : g_body
            assign w_prev_ge  = w_ge[i-1];
            assign w_prev_val = w_val[i-1];
        end

        if (i == CAPACITY - 1) begin : g_tail
            assign w_next_val = w_val[i];
        end else begin : g_mid
            assign w_next_val = w_val[i+1];
        end

        spq_cell u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (w_ctrl),
            .i_occupied   (w_occ),
            .i_prev_ge    (w_prev_ge),
            .i_prev_value (w_prev_val),
            .i_next_value (w_next_val),
            .o_value      (w_val[i]),
            .o_ge         (w_ge[i])
        );
    end

    // occupancy and strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= w_accept;
            if (w_accept) begin
                r_count <= n_count;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_result <= n_result;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

// ===== rtl/spq_cell.sv =====
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain. Compares its entry with the broadcast value
// and, on insert or remove, keeps its entry, takes the new value or takes one from a neighbour.
// ----------------------------------------------------------------------------
module spq_cell
    import spq_pkg::*;
(
    input  logic       i_clk,
    input  t_cell_ctrl i_ctrl,
    input  logic       i_occupied,
    input  logic       i_prev_ge,
    input  t_value     i_prev_value,
    input  t_value     i_next_value,
    output t_value     o_value,
    output logic       o_ge
);

    t_value r_value;
    t_value n_value;

    // occupied entry that stays ahead of the new value
    assign o_ge    = i_occupied && (r_value >= i_ctrl.value);
    assign o_value = r_value;

    // shift towards the tail on insert, towards the head on remove
    always_comb begin
        n_value = r_value;
        if (i_ctrl.insert) begin
            if (!o_ge) begin
                n_value = i_prev_ge ? i_ctrl.value : i_prev_value;
            end
        end else if (i_ctrl.remove) begin
            n_value = i_next_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule
